>>> rtl/ctri_pkg.sv
package ctri_pkg;

    // Digit width into which the multiplier splits its operands for the partial products
    localparam int MUL_DIGIT = 34;

    // Register stages of one multiplier: magnitude, partial products,
    // row sums, total, sign
    localparam int MUL_LAT = 5;

    // Region of the query point
    typedef enum logic [2:0] {
        REG_A    = 3'd0,
        REG_B    = 3'd1,
        REG_AB   = 3'd2,
        REG_C    = 3'd3,
        REG_AC   = 3'd4,
        REG_BC   = 3'd5,
        REG_FACE = 3'd6
    } region_t;

endpackage

>>> rtl/closest_point_on_triangle.sv
// Channel | Dir | Fields (lowest bits first)
// s_      | in  | tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z p_x p_y p_z
// m_      | out | tdata: q_x q_y q_z; tuser: region
//
// One item per cycle sustained while m_ does not stall.
// The latency is set by the three multiplier ranks and by the restoring divider,
// which resolves one quotient bit per stage over COORD_WIDTH + 3 stages.
// aresetn clears the valid bits and the output stage; payload is not reset.
// A stall at m_ parks one result in a skid register; s_tready then drops and the
// whole pipeline holds until the skid register drains.
module closest_point_on_triangle import ctri_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // a_x a_y a_z b_x b_y b_z c_x c_y c_z p_x p_y p_z
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // q_x q_y q_z
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    // region
    output logic [2:0] m_tuser
);

    localparam int W       = COORD_WIDTH;
    localparam int E       = W + 1;
    localparam int DW      = 2 * E + 2;
    localparam int VW      = 2 * DW + 1;
    localparam int DENW    = VW + 2;
    localparam int PNW     = DENW + E;
    localparam int XW      = PNW + 1;
    localparam int NW      = XW + 2;
    localparam int DDW     = DENW + 1;
    localparam int QB      = W + 3;
    localparam int SW      = QB + 2;
    localparam int DIV_LAT = QB + 2;
    localparam int OUT_TW  = ((3 * W + 7) / 8) * 8;
    localparam int L_DIFF  = 1;
    localparam int L_DOT   = L_DIFF + MUL_LAT + 1;
    localparam int L_V     = L_DOT + MUL_LAT + 1;
    localparam int L_S     = L_V + 1;
    localparam int L_R     = L_S + 1;
    localparam int L_C     = L_R + 1;
    localparam int L_X     = L_C + MUL_LAT + 1;
    localparam int L_Q     = L_X + DIV_LAT;
    localparam int PD      = L_Q + 1;
    localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SAT_LO = -(SW'(1) <<< (W - 1));

    localparam int XA [6] = '{0, 2, 4, 0, 2, 4};
    localparam int XB [6] = '{3, 1, 1, 5, 5, 3};

    logic en;
    logic [PD-1:0] vld_reg;

    // ---------------- input unpack and differences ----------------
    logic signed [W-1:0] in_a [3], in_b [3], in_c [3], in_p [3];
    logic signed [W-1:0] a_reg [3], b_reg [3], c_reg [3];
    logic signed [E-1:0] ab_reg [3], ac_reg [3], bc_reg [3];
    logic signed [E-1:0] ap_reg [3], bp_reg [3], cp_reg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_a[k] = s_tdata[k*W +: W];
            in_b[k] = s_tdata[(3+k)*W +: W];
            in_c[k] = s_tdata[(6+k)*W +: W];
            in_p[k] = s_tdata[(9+k)*W +: W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                a_reg[k]  <= in_a[k];
                b_reg[k]  <= in_b[k];
                c_reg[k]  <= in_c[k];
                ab_reg[k] <= E'(in_b[k]) - E'(in_a[k]);
                ac_reg[k] <= E'(in_c[k]) - E'(in_a[k]);
                bc_reg[k] <= E'(in_c[k]) - E'(in_b[k]);
                ap_reg[k] <= E'(in_p[k]) - E'(in_a[k]);
                bp_reg[k] <= E'(in_p[k]) - E'(in_b[k]);
                cp_reg[k] <= E'(in_p[k]) - E'(in_c[k]);
            end
        end
    end

    // ---------------- dot products d1..d6 ----------------
    logic signed [2*E-1:0] dprod [6][3];
    logic signed [DW-1:0]  d_reg [6];

    for (genvar g = 0; g < 6; g++) begin : g_dot
        for (genvar k = 0; k < 3; k++) begin : g_axis
            ctri_mul #(.WA(E), .WB(E)) u_mul (
                .aclk (aclk),
                .en   (en),
                .a    ((g % 2 == 0) ? ab_reg[k] : ac_reg[k]),
                .b    ((g / 2 == 0) ? ap_reg[k] : ((g / 2 == 1) ? bp_reg[k] : cp_reg[k])),
                .p    (dprod[g][k])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < 6; g++) begin
                d_reg[g] <= DW'(dprod[g][0]) + DW'(dprod[g][1]) + DW'(dprod[g][2]);
            end
        end
    end

    // ---------------- cross terms ----------------
    logic signed [2*DW-1:0] xprod [6];
    logic [6*DW-1:0]        d_pk, d_dly_pk;
    logic signed [DW-1:0]   dv_reg [6];
    logic signed [VW-1:0]   va_reg, vb_reg, vc_reg;

    for (genvar g = 0; g < 6; g++) begin : g_cross
        ctri_mul #(.WA(DW), .WB(DW)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (d_reg[XA[g]]),
            .b    (d_reg[XB[g]]),
            .p    (xprod[g])
        );
    end

    always_comb begin
        for (int g = 0; g < 6; g++) begin
            d_pk[g*DW +: DW] = d_reg[g];
        end
    end

    ctri_dly #(.WIDTH(6 * DW), .DEPTH(MUL_LAT)) u_d_dly (
        .aclk (aclk),
        .en   (en),
        .d    (d_pk),
        .q    (d_dly_pk)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < 6; g++) begin
                dv_reg[g] <= d_dly_pk[g*DW +: DW];
            end
            vc_reg <= VW'(xprod[0]) - VW'(xprod[1]);
            vb_reg <= VW'(xprod[2]) - VW'(xprod[3]);
            va_reg <= VW'(xprod[4]) - VW'(xprod[5]);
        end
    end

    // ---------------- denominators ----------------
    logic signed [DW-1:0]   sd_reg [6];
    logic signed [VW-1:0]   sva_reg, svb_reg, svc_reg;
    logic signed [DENW-1:0] den_face_reg;
    logic signed [DW:0]     e43_reg, e56_reg, den_ab_reg, den_ac_reg;
    logic signed [DW+1:0]   den_bc_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg       <= dv_reg;
            sva_reg      <= va_reg;
            svb_reg      <= vb_reg;
            svc_reg      <= vc_reg;
            den_face_reg <= DENW'(va_reg) + DENW'(vb_reg) + DENW'(vc_reg);
            den_ab_reg   <= (DW+1)'(dv_reg[0]) - (DW+1)'(dv_reg[2]);
            den_ac_reg   <= (DW+1)'(dv_reg[1]) - (DW+1)'(dv_reg[5]);
            e43_reg      <= (DW+1)'(dv_reg[3]) - (DW+1)'(dv_reg[2]);
            e56_reg      <= (DW+1)'(dv_reg[4]) - (DW+1)'(dv_reg[5]);
            den_bc_reg   <= (DW+2)'(dv_reg[3]) - (DW+2)'(dv_reg[2])
                          + (DW+2)'(dv_reg[4]) - (DW+2)'(dv_reg[5]);
        end
    end

    // Carry vertices and edge vectors up to the region decision
    logic [9*W-1:0] vtx_pk, vtx_dly_pk;
    logic [9*E-1:0] dir_pk, dir_dly_pk;
    logic signed [W-1:0] sa [3], sb [3], sc [3];
    logic signed [E-1:0] sab [3], sac [3], sbc [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vtx_pk[k*W +: W]     = a_reg[k];
            vtx_pk[(3+k)*W +: W] = b_reg[k];
            vtx_pk[(6+k)*W +: W] = c_reg[k];
            dir_pk[k*E +: E]     = ab_reg[k];
            dir_pk[(3+k)*E +: E] = ac_reg[k];
            dir_pk[(6+k)*E +: E] = bc_reg[k];
            sa[k]  = vtx_dly_pk[k*W +: W];
            sb[k]  = vtx_dly_pk[(3+k)*W +: W];
            sc[k]  = vtx_dly_pk[(6+k)*W +: W];
            sab[k] = dir_dly_pk[k*E +: E];
            sac[k] = dir_dly_pk[(3+k)*E +: E];
            sbc[k] = dir_dly_pk[(6+k)*E +: E];
        end
    end

    ctri_dly #(.WIDTH(9 * W), .DEPTH(L_S - L_DIFF)) u_vtx_dly (
        .aclk (aclk),
        .en   (en),
        .d    (vtx_pk),
        .q    (vtx_dly_pk)
    );

    ctri_dly #(.WIDTH(9 * E), .DEPTH(L_S - L_DIFF)) u_dir_dly (
        .aclk (aclk),
        .en   (en),
        .d    (dir_pk),
        .q    (dir_dly_pk)
    );

    // ---------------- region decision ----------------
    logic cond_a, cond_b, cond_ab, cond_c, cond_ac, cond_bc;
    region_t                region_next, region_reg;
    logic signed [W-1:0]    base_next [3], base_reg [3];
    logic signed [E-1:0]    dir1_next [3], dir1_reg [3];
    logic signed [E-1:0]    dir2_next [3], dir2_reg [3];
    logic signed [DENW-1:0] num1_next, num2_next, den_next;
    logic signed [DENW-1:0] num1_reg, num2_reg, den_reg;

    assign cond_a  = (sd_reg[0] <= 0) && (sd_reg[1] <= 0);
    assign cond_b  = (sd_reg[2] >= 0) && (sd_reg[2] >= sd_reg[3]);
    assign cond_ab = (svc_reg <= 0) && (sd_reg[0] >= 0) && (sd_reg[2] <= 0);
    assign cond_c  = (sd_reg[5] >= 0) && (sd_reg[5] >= sd_reg[4]);
    assign cond_ac = (svb_reg <= 0) && (sd_reg[1] >= 0) && (sd_reg[5] <= 0);
    assign cond_bc = (sva_reg <= 0) && (e43_reg >= 0) && (e56_reg >= 0);

    // Pick base, directions, numerators and denominator in test order
    always_comb begin
        region_next = REG_FACE;
        base_next   = sa;
        dir1_next   = sab;
        dir2_next   = sac;
        num1_next   = DENW'(svb_reg);
        num2_next   = DENW'(svc_reg);
        den_next    = den_face_reg;
        if (cond_a) begin
            region_next = REG_A;
            num1_next   = '0;
            num2_next   = '0;
            den_next    = DENW'(1);
        end else if (cond_b) begin
            region_next = REG_B;
            base_next   = sb;
            num1_next   = '0;
            num2_next   = '0;
            den_next    = DENW'(1);
        end else if (cond_ab) begin
            region_next = REG_AB;
            num1_next   = DENW'(sd_reg[0]);
            num2_next   = '0;
            den_next    = DENW'(den_ab_reg);
        end else if (cond_c) begin
            region_next = REG_C;
            base_next   = sc;
            num1_next   = '0;
            num2_next   = '0;
            den_next    = DENW'(1);
        end else if (cond_ac) begin
            region_next = REG_AC;
            dir1_next   = sac;
            num1_next   = DENW'(sd_reg[1]);
            num2_next   = '0;
            den_next    = DENW'(den_ac_reg);
        end else if (cond_bc) begin
            region_next = REG_BC;
            base_next   = sb;
            dir1_next   = sbc;
            num1_next   = DENW'(e43_reg);
            num2_next   = '0;
            den_next    = DENW'(den_bc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            region_reg <= region_next;
            base_reg   <= base_next;
            dir1_reg   <= dir1_next;
            dir2_reg   <= dir2_next;
            num1_reg   <= num1_next;
            num2_reg   <= num2_next;
            den_reg    <= den_next;
        end
    end

    // ---------------- clamp ratios ----------------
    logic                   den_pos;
    logic signed [DENW-1:0] n1_next, n2_next;
    logic signed [DENW-1:0] n1_reg, n2_reg, deff_reg;
    region_t                cregion_reg;
    logic signed [W-1:0]    cbase_reg [3];
    logic signed [E-1:0]    cdir1_reg [3], cdir2_reg [3];

    assign den_pos = den_reg > 0;
    assign n1_next = (!den_pos || num1_reg <= 0) ? '0
                   : ((num1_reg >= den_reg) ? den_reg : num1_reg);
    assign n2_next = (!den_pos || num2_reg <= 0) ? '0
                   : ((num2_reg >= den_reg) ? den_reg : num2_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg      <= n1_next;
            n2_reg      <= n2_next;
            deff_reg    <= den_pos ? den_reg : DENW'(1);
            cregion_reg <= region_reg;
            cbase_reg   <= base_reg;
            cdir1_reg   <= dir1_reg;
            cdir2_reg   <= dir2_reg;
        end
    end

    // ---------------- weighted directions ----------------
    logic signed [PNW-1:0]  np1 [3], np2 [3];
    logic [DENW-1:0]        deff_dly;
    logic signed [XW-1:0]   xs [3];
    logic signed [NW-1:0]   num_reg [3];
    logic [DDW-1:0]         dd_reg;

    for (genvar k = 0; k < 3; k++) begin : g_weight
        ctri_mul #(.WA(DENW), .WB(E)) u_mul1 (
            .aclk (aclk),
            .en   (en),
            .a    (n1_reg),
            .b    (cdir1_reg[k]),
            .p    (np1[k])
        );
        ctri_mul #(.WA(DENW), .WB(E)) u_mul2 (
            .aclk (aclk),
            .en   (en),
            .a    (n2_reg),
            .b    (cdir2_reg[k]),
            .p    (np2[k])
        );
    end

    ctri_dly #(.WIDTH(DENW), .DEPTH(MUL_LAT)) u_den_dly (
        .aclk (aclk),
        .en   (en),
        .d    (deff_reg),
        .q    (deff_dly)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            xs[k] = XW'(np1[k]) + XW'(np2[k]);
        end
    end

    // Round to nearest, ties up: floor((2x + den) / (2den))
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                num_reg[k] <= (NW'(xs[k]) <<< 1) + NW'($signed(deff_dly));
            end
            dd_reg <= {deff_dly, 1'b0};
        end
    end

    // ---------------- division ----------------
    logic signed [QB:0] qd [3];

    for (genvar k = 0; k < 3; k++) begin : g_div
        ctri_div #(.NW(NW), .DWD(DDW), .QB(QB)) u_div (
            .aclk (aclk),
            .en   (en),
            .n    (num_reg[k]),
            .d    (dd_reg),
            .q    (qd[k])
        );
    end

    logic [3*W+2:0]      bq_pk, bq_dly_pk;
    logic signed [W-1:0] bq [3];
    logic signed [SW-1:0] sum [3];
    logic [W-1:0]        fin_q_reg [3];
    logic [2:0]          fin_region_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            bq_pk[k*W +: W] = cbase_reg[k];
            bq[k]           = bq_dly_pk[k*W +: W];
            sum[k]          = SW'(bq[k]) + SW'(qd[k]);
        end
        bq_pk[3*W +: 3] = cregion_reg;
    end

    ctri_dly #(.WIDTH(3 * W + 3), .DEPTH(L_Q - L_C)) u_base_dly (
        .aclk (aclk),
        .en   (en),
        .d    (bq_pk),
        .q    (bq_dly_pk)
    );

    // Add base point and saturate to the coordinate range
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (sum[k] > SAT_HI) begin
                    fin_q_reg[k] <= W'(SAT_HI);
                end else if (sum[k] < SAT_LO) begin
                    fin_q_reg[k] <= W'(SAT_LO);
                end else begin
                    fin_q_reg[k] <= W'(sum[k]);
                end
            end
            fin_region_reg <= bq_dly_pk[3*W +: 3];
        end
    end

    // ---------------- output register and skid ----------------
    logic [3*W+2:0] pipe_data;
    logic [3*W+2:0] m_data_reg, skid_data_reg;
    logic           m_valid_reg, skid_valid_reg;
    logic           out_free;

    assign pipe_data = {fin_region_reg, fin_q_reg[2], fin_q_reg[1], fin_q_reg[0]};
    assign out_free  = m_tready || !m_valid_reg;
    assign en        = !skid_valid_reg;
    assign s_tready  = en;

    // Advance valid bits; move results into the output or skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[PD-2:0], s_tvalid};
            end
            if (out_free) begin
                if (skid_valid_reg) begin
                    m_valid_reg    <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg <= vld_reg[PD-1];
                end
            end else if (en && vld_reg[PD-1]) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : pipe_data;
        end else if (en) begin
            skid_data_reg <= pipe_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TW'(m_data_reg[3*W-1:0]);
    assign m_tuser  = m_data_reg[3*W +: 3];

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds a result while the output is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready && en && vld_reg[PD-1]) |=> skid_valid_reg)
        else $error("finished result dropped during an output stall");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_region_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_tuser <= REG_FACE))
        else $error("region code out of range");

endmodule

>>> rtl/ctri_dly.sv
module ctri_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    // Shift the data along with the pipeline
    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++) begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

>>> rtl/ctri_mul.sv
module ctri_mul import ctri_pkg::*; #(
    parameter int WA = 34,
    parameter int WB = 34
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int NA = (WA + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int NB = (WB + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int AW = NA * MUL_DIGIT;
    localparam int BW = NB * MUL_DIGIT;
    localparam int PW = WA + WB;
    localparam int RW = BW + MUL_DIGIT;
    localparam int TW = AW + BW;

    logic [WA-1:0]            abs_a_next;
    logic [WB-1:0]            abs_b_next;
    logic [AW-1:0]            mag_a_reg;
    logic [BW-1:0]            mag_b_reg;
    logic [MUL_LAT-2:0]       neg_reg;
    logic [2*MUL_DIGIT-1:0]   pp_reg [NA][NB];
    logic [RW-1:0]            row_next [NA];
    logic [RW-1:0]            row_reg [NA];
    logic [TW-1:0]            tot_next;
    logic [PW-1:0]            tot_reg;
    logic signed [PW-1:0]     p_reg;

    assign abs_a_next = a[WA-1] ? WA'(-a) : WA'(a);
    assign abs_b_next = b[WB-1] ? WB'(-b) : WB'(b);

    // Sum the partial products of each digit of a
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++) begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (j * MUL_DIGIT));
            end
        end
    end

    // Sum the rows
    always_comb begin
        tot_next = '0;
        for (int i = 0; i < NA; i++) begin
            tot_next = tot_next + (TW'(row_reg[i]) << (i * MUL_DIGIT));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_a_reg <= AW'(abs_a_next);
            mag_b_reg <= BW'(abs_b_next);
            neg_reg   <= {neg_reg[MUL_LAT-3:0], a[WA-1] ^ b[WB-1]};
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= mag_a_reg[i*MUL_DIGIT +: MUL_DIGIT]
                                  * mag_b_reg[j*MUL_DIGIT +: MUL_DIGIT];
                end
            end
            row_reg <= row_next;
            tot_reg <= PW'(tot_next);
            p_reg   <= neg_reg[MUL_LAT-2] ? -$signed(tot_reg) : $signed(tot_reg);
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/ctri_div.sv
module ctri_div #(
    parameter int NW  = 16,
    parameter int DWD = 8,
    parameter int QB  = 8
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [NW-1:0] n,
    input  logic [DWD-1:0]      d,
    output logic signed [QB:0]  q
);

    localparam int MW = NW + 1;
    localparam int RW = ((MW > DWD + QB) ? MW : DWD + QB) + 1;

    logic signed [MW-1:0] n_ext;
    logic [MW-1:0]        n_mag;
    logic [RW-1:0]        nm_next;
    logic [RW-1:0]        r_reg [QB];
    logic [DWD-1:0]       d_reg [QB];
    logic [QB-1:0]        q_reg [QB+1];
    logic                 neg_reg [QB+1];
    logic [RW-1:0]        sh [QB];
    logic                 ge [QB];
    logic signed [QB:0]   q_out_reg;

    assign n_ext = MW'(n);
    assign n_mag = ~n_ext + 1'b1;

    // Floor division of a negative numerator runs on (-n + d - 1)
    assign nm_next = n[NW-1] ? (RW'(n_mag) + RW'(d) - RW'(1)) : RW'(n_ext);

    // Trial subtract of the shifted divisor, one quotient bit per stage
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            sh[k] = RW'(d_reg[k]) << (QB - 1 - k);
            ge[k] = r_reg[k] >= sh[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= nm_next;
            d_reg[0]   <= d;
            q_reg[0]   <= '0;
            neg_reg[0] <= n[NW-1];
            for (int k = 0; k < QB; k++) begin
                q_reg[k+1]   <= q_reg[k] | (ge[k] ? (QB'(1) << (QB - 1 - k)) : '0);
                neg_reg[k+1] <= neg_reg[k];
            end
            for (int k = 0; k < QB - 1; k++) begin
                r_reg[k+1] <= ge[k] ? (r_reg[k] - sh[k]) : r_reg[k];
                d_reg[k+1] <= d_reg[k];
            end
            q_out_reg <= neg_reg[QB] ? -$signed({1'b0, q_reg[QB]})
                                     : $signed({1'b0, q_reg[QB]});
        end
    end

    assign q = q_out_reg;

endmodule
